### sv/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: channel payload
// widths, action codes, register indexes and character control codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Payload field widths.
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int ATTR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int CFG_IDX_W = 1;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [IDX_W-1:0]    cell_idx_t;
  typedef logic [ATTR_W-1:0]   attr_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Action codes carried by a request.
  localparam action_t ACT_PUT   = 2'd0;
  localparam action_t ACT_READ  = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t REG_FG = 1'd0;
  localparam cfg_idx_t REG_BG = 1'd1;

  // Control characters and fixed values.
  localparam char_t CODE_NEWLINE   = 8'd10;
  localparam char_t CODE_RETURN    = 8'd13;
  localparam char_t CODE_TAB       = 8'd9;
  localparam char_t CODE_BACKSPACE = 8'h08;
  localparam char_t BLANK_CHAR     = 8'h20;
  localparam int    TAB_STEP       = 4;

  // Reset values of the color registers.
  localparam color_t FG_RESET = 4'd0;
  localparam color_t BG_RESET = 4'd15;

endpackage

### sv/tcw_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel: one action with its character and cell index.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
  logic      valid;
  logic      ready;
  action_t   action;
  char_t     character;
  cell_idx_t cell_index;

  modport source (output valid, action, character, cell_index, input ready);
  modport sink (input valid, action, character, cell_index, output ready);
endinterface

### sv/tcw_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: cursor position, read cell contents and scroll flag.
// ----------------------------------------------------------------------------
interface tcw_rsp_if import tcw_pkg::*; ();
  logic      valid;
  logic      ready;
  cell_idx_t cursor_index;
  char_t     read_char;
  attr_t     read_attr;
  logic      scrolled;

  modport source (output valid, cursor_index, read_char, read_attr, scrolled,
                  input ready);
  modport sink (input valid, cursor_index, read_char, read_attr, scrolled,
                output ready);
endinterface

### sv/tcw_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcw_cfg_if import tcw_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  color_t   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell screen with a cursor: puts characters, reads cells, clears
// the screen and scrolls it up one row when the cursor runs off the end.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one action per transaction; rsp returns exactly one result per
//   request, in order. cfg writes foreground (index 0) and background (index 1)
//   colors; always ready, it must be used only while idle (the block does not check).
// Per action (N = ROWS * COLUMNS):
//   Put without scroll, cursor moves and the unused action: the result is
//   registered at the accepting edge, so the next request can follow once it drains.
//   Read: passes through S_READ, which waits for the registered screen memory read.
//   Clear: S_FILL writes all N cells, one screen memory write per cycle.
//   Put that scrolls: the shared memory port copies each
//   row up one cell per cycle (read and write overlapped), then zeroes the
//   bottom row.
// Reset: a clearing pass writes zero to all N cells, during which no request
//   is accepted. Colors reset to 0 / 15, the cursor to 0.
// Stalls: the result register holds while rsp.ready is low; a new request is
//   accepted only when the result register is empty or drains that cycle.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic       clk,
  input logic       rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp,
  tcw_cfg_if.sink   cfg
);

  localparam int CELL_TOTAL = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELL_TOTAL);
  localparam int PTR_W   = $clog2(CELL_TOTAL + 1);
  localparam int CUR_W   = $clog2(CELL_TOTAL + TAB_STEP);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int COLX_W  = $clog2(COLUMNS + TAB_STEP);
  localparam int WIDE_W  = (PTR_W > IDX_W) ? PTR_W : IDX_W;
  localparam int CELL_W  = ATTR_W + CHAR_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_COPY = 4'b0100,
    S_FILL = 4'b1000
  } state_t;

  // Screen memory and its registered read data.
  logic [CELL_W-1:0] screen [CELL_TOTAL];
  logic [CELL_W-1:0] mem_rdata;

  // Control and payload registers.
  state_t            state, state_next;
  logic [ADDR_W-1:0] cursor, cursor_next;
  logic [COL_W-1:0]  col, col_next;
  color_t            fg, fg_next;
  color_t            bg, bg_next;
  logic [PTR_W-1:0]  sweep, sweep_next;
  logic [PTR_W-1:0]  src_ptr, src_next;
  logic              copy_pend, copy_pend_next;
  logic [CELL_W-1:0] fill_data, fill_data_next;
  logic              give_result, give_result_next;
  logic              rd_ok, rd_ok_next;
  logic              res_valid, res_valid_next;
  cell_idx_t         res_cursor, res_cursor_next;
  char_t             res_char, res_char_next;
  attr_t             res_attr, res_attr_next;
  logic              res_scrolled, res_scrolled_next;

  // Memory port controls.
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data;

  // Cursor arithmetic.
  logic              accept;
  attr_t             attr;
  logic [CUR_W-1:0]  cur_ext, row_base, target;
  logic [COLX_W-1:0] col_ext, col_step, target_col;
  logic              scroll;
  logic [WIDE_W-1:0] idx_wide, cursor_wide;
  logic              idx_in_range;
  logic              issue;

  assign attr      = {bg, fg};
  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!res_valid || rsp.ready);
  assign cfg.ready = 1'b1;

  assign rsp.valid        = res_valid;
  assign rsp.cursor_index = res_cursor;
  assign rsp.read_char    = res_char;
  assign rsp.read_attr    = res_attr;
  assign rsp.scrolled     = res_scrolled;

  assign idx_wide     = WIDE_W'(req.cell_index);
  assign idx_in_range = idx_wide < WIDE_W'(CELL_TOTAL);
  assign issue        = src_ptr < PTR_W'(CELL_TOTAL);

  // Cursor target for a put action, before any scroll correction.
  always_comb begin
    cur_ext  = CUR_W'(cursor);
    col_ext  = COLX_W'(col);
    row_base = cur_ext - CUR_W'(col);
    target     = cur_ext;
    target_col = col_ext;
    col_step   = '0;
    case (req.character)
      CODE_NEWLINE: begin
        target     = row_base + CUR_W'(COLUMNS);
        target_col = '0;
      end
      CODE_RETURN: begin
        target     = row_base;
        target_col = '0;
      end
      CODE_TAB: begin
        target   = cur_ext + CUR_W'(TAB_STEP);
        col_step = col_ext + COLX_W'(TAB_STEP);
        target_col = (col_step >= COLX_W'(COLUMNS)) ? col_step - COLX_W'(COLUMNS)
                                                    : col_step;
      end
      CODE_BACKSPACE: begin
        if (cursor != '0) begin
          target     = cur_ext - CUR_W'(1);
          target_col = (col == '0) ? COLX_W'(COLUMNS - 1) : col_ext - COLX_W'(1);
        end
      end
      default: begin
        target   = cur_ext + CUR_W'(1);
        col_step = col_ext + COLX_W'(1);
        target_col = (col_step >= COLX_W'(COLUMNS)) ? '0 : col_step;
      end
    endcase
    scroll = target >= CUR_W'(CELL_TOTAL);
  end

  // Sequencer: accepts requests and drives the shared memory port.
  always_comb begin
    state_next        = state;
    cursor_next       = cursor;
    col_next          = col;
    fg_next           = fg;
    bg_next           = bg;
    sweep_next        = sweep;
    src_next          = src_ptr;
    copy_pend_next    = copy_pend;
    fill_data_next    = fill_data;
    give_result_next  = give_result;
    rd_ok_next        = rd_ok;
    res_valid_next    = res_valid && !rsp.ready;
    res_cursor_next   = res_cursor;
    res_char_next     = res_char;
    res_attr_next     = res_attr;
    res_scrolled_next = res_scrolled;
    wr_en   = 1'b0;
    wr_addr = cursor;
    wr_data = {attr, req.character};
    rd_en   = 1'b0;
    rd_addr = idx_wide[ADDR_W-1:0];

    // Configuration transactions.
    if (cfg.valid) begin
      case (cfg.index)
        REG_FG:  fg_next = cfg.data;
        REG_BG:  bg_next = cfg.data;
        default: ;
      endcase
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_char_next     = '0;
          res_attr_next     = '0;
          res_scrolled_next = 1'b0;
          res_valid_next    = 1'b1;
          case (req.action)
            ACT_PUT: begin
              // Backspace (unless at cell 0) and every character but newline, return and tab write one cell.
              if (req.character == CODE_BACKSPACE) begin
                wr_en   = (cursor != '0);
                wr_addr = cursor - ADDR_W'(1);
                wr_data = {attr, BLANK_CHAR};
              end else if (req.character != CODE_NEWLINE &&
                           req.character != CODE_RETURN &&
                           req.character != CODE_TAB) begin
                wr_en = 1'b1;
              end
              col_next = target_col[COL_W-1:0];
              if (scroll) begin
                cursor_next       = ADDR_W'(target - CUR_W'(COLUMNS));
                res_scrolled_next = 1'b1;
                res_valid_next    = 1'b0;
                give_result_next  = 1'b1;
                sweep_next        = '0;
                src_next          = PTR_W'(COLUMNS);
                copy_pend_next    = 1'b0;
                state_next        = S_COPY;
              end else begin
                cursor_next = target[ADDR_W-1:0];
              end
            end
            ACT_READ: begin
              rd_en          = idx_in_range;
              rd_ok_next     = idx_in_range;
              res_valid_next = 1'b0;
              state_next     = S_READ;
            end
            ACT_CLEAR: begin
              cursor_next      = '0;
              col_next         = '0;
              fill_data_next   = {attr, BLANK_CHAR};
              sweep_next       = '0;
              give_result_next = 1'b1;
              res_valid_next   = 1'b0;
              state_next       = S_FILL;
            end
            default: ;
          endcase
          res_cursor_next = WIDE_W'(cursor_next) == '0 ? '0
                          : cursor_wide[IDX_W-1:0];
        end
      end

      S_READ: begin
        // Registered read data is available in the cycle after the request is accepted.
        res_char_next  = rd_ok ? mem_rdata[CHAR_W-1:0] : '0;
        res_attr_next  = rd_ok ? mem_rdata[CELL_W-1:CHAR_W] : '0;
        res_valid_next = 1'b1;
        state_next     = S_IDLE;
      end

      S_COPY: begin
        // Read one row ahead and write the data back in the following cycle.
        if (issue) begin
          rd_en    = 1'b1;
          rd_addr  = src_ptr[ADDR_W-1:0];
          src_next = src_ptr + PTR_W'(1);
        end
        if (copy_pend) begin
          wr_en      = 1'b1;
          wr_addr    = sweep[ADDR_W-1:0];
          wr_data    = mem_rdata;
          sweep_next = sweep + PTR_W'(1);
        end
        copy_pend_next = issue;
        if (!issue && !copy_pend) begin
          fill_data_next = '0;
          state_next     = S_FILL;
        end
      end

      S_FILL: begin
        // Fill from the sweep pointer to the last cell.
        wr_en      = 1'b1;
        wr_addr    = sweep[ADDR_W-1:0];
        wr_data    = fill_data;
        sweep_next = sweep + PTR_W'(1);
        if (sweep == PTR_W'(CELL_TOTAL - 1)) begin
          state_next     = S_IDLE;
          res_valid_next = give_result;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Cursor as reported, extended to WIDE_W bits and then cut to the result field width.
  assign cursor_wide = WIDE_W'(cursor_next);

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      screen[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rdata <= screen[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      cursor      <= '0;
      col         <= '0;
      fg          <= FG_RESET;
      bg          <= BG_RESET;
      sweep       <= '0;
      src_ptr     <= '0;
      copy_pend   <= 1'b0;
      fill_data   <= '0;
      give_result <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cursor      <= cursor_next;
      col         <= col_next;
      fg          <= fg_next;
      bg          <= bg_next;
      sweep       <= sweep_next;
      src_ptr     <= src_next;
      copy_pend   <= copy_pend_next;
      fill_data   <= fill_data_next;
      give_result <= give_result_next;
      res_valid   <= res_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    rd_ok        <= rd_ok_next;
    res_cursor   <= res_cursor_next;
    res_char     <= res_char_next;
    res_attr     <= res_attr_next;
    res_scrolled <= res_scrolled_next;
  end

endmodule

### tb/sv/text_console_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking testbench for the text console writer. A clocked driver
// feeds request transactions from a queue of pending actions, and a clocked
// monitor keeps a shadow screen, cursor and color pair. For every accepted
// request it computes the expected response, and it compares each accepted
// response field by field. Phases under several color settings run a short
// directed set, then randomized typing, row fills, newline bursts, reads,
// clears and noise, with random gaps on the request side and random stalls
// on the response side in every phase but one.
// ----------------------------------------------------------------------------
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELLS        = ROWS * COLUMNS;
  localparam int QUIET_LIMIT  = 10 * CELLS;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 50;

  typedef struct {
    action_t   action;
    char_t     character;
    cell_idx_t cell_index;
  } console_req_t;

  typedef struct {
    cell_idx_t cursor_index;
    char_t     read_char;
    attr_t     read_attr;
    logic      scrolled;
  } console_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Signals driven by the testbench, known from time zero.
  logic         req_valid = 1'b0;
  console_req_t req_item  = '{ACT_PUT, '0, '0};
  logic         rsp_ready = 1'b0;
  logic         cfg_valid = 1'b0;
  cfg_idx_t     cfg_index = REG_FG;
  color_t       cfg_data  = '0;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();
  tcw_cfg_if cfg_ch ();

  assign req_ch.valid      = req_valid;
  assign req_ch.action     = req_item.action;
  assign req_ch.character  = req_item.character;
  assign req_ch.cell_index = req_item.cell_index;
  assign rsp_ch.ready      = rsp_ready;
  assign cfg_ch.valid      = cfg_valid;
  assign cfg_ch.index      = cfg_index;
  assign cfg_ch.data       = cfg_data;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Actions waiting to be sent and responses still owed by the block.
  console_req_t pending_actions[$];
  console_rsp_t owed_responses[$];

  // Shadow copy of the screen, cursor and colors.
  logic [15:0] shadow_screen [CELLS];
  int          shadow_cursor;
  color_t      shadow_fg;
  color_t      shadow_bg;

  int error_count = 0;
  int queued_count = 0;
  int quiet_cycles = 0;
  int gap_pct = 20;
  int stall_pct = 20;

  always #5 clk = ~clk;

  // Compute the response to one action and update the shadow state.
  function automatic console_rsp_t next_console_result(action_t act, char_t ch,
                                                       cell_idx_t idx);
    console_rsp_t res;
    int cur;
    int row;
    int i;
    begin
      res = '{'0, '0, '0, 1'b0};
      cur = shadow_cursor;
      case (act)
        ACT_PUT: begin
          row = cur / COLUMNS;
          if (ch == CODE_NEWLINE) begin
            cur = (row + 1) * COLUMNS;
          end else if (ch == CODE_RETURN) begin
            cur = row * COLUMNS;
          end else if (ch == CODE_TAB) begin
            cur = cur + TAB_STEP;
          end else if (ch == CODE_BACKSPACE) begin
            // Backspace at the first cell leaves everything alone.
            if (cur > 0) begin
              cur = cur - 1;
              shadow_screen[cur] = {shadow_bg, shadow_fg, BLANK_CHAR};
            end
          end else begin
            shadow_screen[cur] = {shadow_bg, shadow_fg, ch};
            cur = cur + 1;
          end
          // Running off the end moves every row up and zero-fills the last.
          if (cur >= CELLS) begin
            for (i = 0; i < CELLS - COLUMNS; i++) begin
              shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            for (i = CELLS - COLUMNS; i < CELLS; i++) begin
              shadow_screen[i] = '0;
            end
            cur = cur - COLUMNS;
            res.scrolled = 1'b1;
          end
          shadow_cursor = cur;
        end
        ACT_READ: begin
          if (idx < CELLS) begin
            res.read_char = shadow_screen[idx][7:0];
            res.read_attr = shadow_screen[idx][15:8];
          end
        end
        ACT_CLEAR: begin
          for (i = 0; i < CELLS; i++) begin
            shadow_screen[i] = {shadow_bg, shadow_fg, BLANK_CHAR};
          end
          shadow_cursor = 0;
        end
        default: begin
        end
      endcase
      res.cursor_index = cell_idx_t'(shadow_cursor);
      return res;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v,
                                      logic [15:0] got_v);
    begin
      if (got_v !== exp_v) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                 exp_v, got_v);
        error_count++;
      end
    end
  endfunction

  // Driver: present the next pending action and drive response ready.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_ready <= 1'b0;
    end else begin
      if (!req_valid || req_ch.ready) begin
        if (pending_actions.size() != 0 && $urandom_range(99) >= gap_pct) begin
          req_item  <= pending_actions.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: track color writes, predict on requests, check responses.
  always @(posedge clk) begin
    console_rsp_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        shadow_screen[i] = '0;
      end
      shadow_cursor = 0;
      shadow_fg = FG_RESET;
      shadow_bg = BG_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_FG: shadow_fg = cfg_ch.data;
          REG_BG: shadow_bg = cfg_ch.data;
          default: begin
          end
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        owed_responses.push_back(next_console_result(req_ch.action,
                                 req_ch.character, req_ch.cell_index));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_responses.size() == 0) begin
          $display("%0t ns: response transaction with none expected, cursor %0d",
                   $time, rsp_ch.cursor_index);
          error_count++;
        end else begin
          want = owed_responses.pop_front();
          check_field("cursor_index", want.cursor_index, rsp_ch.cursor_index);
          check_field("read_char", want.read_char, rsp_ch.read_char);
          check_field("read_attr", want.read_attr, rsp_ch.read_attr);
          check_field("scrolled", want.scrolled, rsp_ch.scrolled);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction completes for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic void push_req(action_t act, char_t ch, cell_idx_t idx);
    begin
      pending_actions.push_back('{act, ch, idx});
      if (act != ACT_PUT + 2'd3) begin
        queued_count++;
      end
    end
  endfunction

  function automatic char_t printable_char();
    return char_t'($urandom_range(32, 126));
  endfunction

  function automatic cell_idx_t any_idx();
    return cell_idx_t'($urandom_range(2047));
  endfunction

  function automatic char_t any_char();
    return char_t'($urandom_range(255));
  endfunction

  // Wait until every action has been sent and answered.
  task automatic wait_idle();
    begin
      do @(negedge clk);
      while (pending_actions.size() != 0 || req_valid || owed_responses.size() != 0);
    end
  endtask

  task automatic write_color(cfg_idx_t which, color_t value);
    begin
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= which;
      cfg_data  <= value;
      do @(posedge clk);
      while (!cfg_ch.ready);
      cfg_valid <= 1'b0;
    end
  endtask

  // Short directed set: field extremes, every action, control codes.
  task automatic add_directed();
    begin
      push_req(ACT_READ, 8'hFF, 11'd0);
      push_req(ACT_READ, 8'h00, 11'd1999);
      push_req(ACT_READ, 8'h00, 11'd2000);
      push_req(ACT_READ, 8'hFF, 11'd2047);
      push_req(ACT_PUT, 8'h41, 11'd2047);
      push_req(ACT_PUT, 8'h00, 11'd0);
      push_req(ACT_PUT, 8'hFF, 11'd0);
      push_req(ACT_PUT, 8'h7F, 11'd0);
      push_req(ACT_PUT, CODE_BACKSPACE, 11'd0);
      push_req(ACT_READ, 8'h00, 11'd3);
      push_req(ACT_PUT, CODE_RETURN, 11'd0);
      push_req(ACT_PUT, CODE_BACKSPACE, 11'd0);
      push_req(ACT_PUT, CODE_TAB, 11'd0);
      push_req(ACT_PUT, CODE_TAB, 11'd0);
      push_req(ACT_PUT, CODE_NEWLINE, 11'd0);
      push_req(ACT_PUT + 2'd3, 8'hFF, 11'd2047);
      push_req(ACT_READ, 8'h00, 11'd0);
      push_req(ACT_READ, 8'h00, 11'd1);
      push_req(ACT_CLEAR, 8'hFF, 11'd2047);
      push_req(ACT_PUT, CODE_BACKSPACE, 11'd0);
      push_req(ACT_READ, 8'h00, 11'd1999);
      push_req(ACT_PUT, 8'h5A, 11'd0);
    end
  endtask

  // Random traffic built mostly from well-formed sequences.
  task automatic add_random_traffic(int target);
    int stop_at;
    int kind;
    int n;
    int k;
    int r;
    char_t c;
    begin
      stop_at = queued_count + target;
      while (queued_count < stop_at) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          // A line of typing with occasional edits, ended by a newline.
          n = $urandom_range(1, 15);
          for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 80) c = printable_char();
            else if (r < 85) c = CODE_BACKSPACE;
            else if (r < 89) c = CODE_TAB;
            else if (r < 92) c = CODE_RETURN;
            else c = any_char();
            push_req(ACT_PUT, c, any_idx());
          end
          push_req(ACT_PUT, CODE_NEWLINE, any_idx());
        end else if (kind < 50) begin
          // Fill a row to its last columns so the cursor wraps or scrolls.
          push_req(ACT_PUT, CODE_NEWLINE, any_idx());
          n = $urandom_range(18, 19);
          for (k = 0; k < n; k++) begin
            push_req(ACT_PUT, CODE_TAB, any_idx());
          end
          n = $urandom_range(0, 4);
          for (k = 0; k < n; k++) begin
            push_req(ACT_PUT, printable_char(), any_idx());
          end
          r = $urandom_range(2);
          if (r == 0) push_req(ACT_PUT, CODE_TAB, any_idx());
          else if (r == 1) push_req(ACT_PUT, printable_char(), any_idx());
          else push_req(ACT_PUT, CODE_BACKSPACE, any_idx());
        end else if (kind < 62) begin
          // Newline burst that walks the cursor down and can scroll at the bottom.
          n = $urandom_range(3, 20);
          for (k = 0; k < n; k++) begin
            push_req(ACT_PUT, CODE_NEWLINE, any_idx());
          end
        end else if (kind < 80) begin
          // Reads, half of them in the bottom rows where text lands.
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(1) == 0) begin
              push_req(ACT_READ, any_char(), any_idx());
            end else begin
              push_req(ACT_READ, any_char(),
                       cell_idx_t'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1)));
            end
          end
        end else if (kind < 83) begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) begin
            push_req(ACT_PUT, CODE_BACKSPACE, any_idx());
          end
        end else if (kind < 85) begin
          push_req(ACT_CLEAR, any_char(), any_idx());
        end else if (kind < 90) begin
          push_req(ACT_PUT + 2'd3, any_char(), any_idx());
        end else begin
          push_req(action_t'($urandom_range(2)), any_char(), any_idx());
        end
      end
    end
  endtask

  // Test sequence: reset, then phases under different color settings.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_directed();
    wait_idle();

    write_color(REG_FG, 4'd15);
    write_color(REG_BG, 4'd0);
    add_random_traffic(PHASE_ITEMS);
    wait_idle();

    // A stretch with no gaps and no stalls at all.
    gap_pct = 0;
    stall_pct = 0;
    write_color(REG_FG, 4'd0);
    add_random_traffic(PHASE_ITEMS);
    wait_idle();
    gap_pct = 20;
    stall_pct = 20;

    write_color(REG_FG, 4'd15);
    write_color(REG_BG, 4'd15);
    add_random_traffic(PHASE_ITEMS);
    wait_idle();

    write_color(REG_FG, color_t'($urandom_range(15)));
    write_color(REG_BG, color_t'($urandom_range(15)));
    add_random_traffic(PHASE_ITEMS);
    wait_idle();

    write_color(REG_BG, color_t'($urandom_range(15)));
    add_random_traffic(PHASE_ITEMS);
    wait_idle();

    // Let the block settle and catch any stray response.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_responses.size() != 0) begin
      $display("%0t ns: %0d responses never arrived", $time, owed_responses.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### text_console_writer.f
sv/tcw_pkg.sv
sv/tcw_req_if.sv
sv/tcw_rsp_if.sv
sv/tcw_cfg_if.sv
sv/text_console_writer.sv
tb/sv/text_console_writer_test.sv
